// File: rtl/i2c_display_slave_responder_assert.svh
`ifndef I2C_DISPLAY_SLAVE_RESPONDER_ASSERT_SVH
`define I2C_DISPLAY_SLAVE_RESPONDER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define I2CDSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define I2CDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i2cdsr_pkg.sv
package i2cdsr_pkg;

    localparam int BYTE_W       = 8;
    localparam int STATUS_DEPTH = 8;
    localparam int STATUS_IDX_W = $clog2(STATUS_DEPTH);
    localparam int CFG_IDX_W    = 2;

    localparam logic [BYTE_W-1:0] DISPLAY_ADDR = 8'h4F;
    localparam logic [BYTE_W-1:0] RANGE_MASK   = 8'hF0;
    localparam logic [BYTE_W-1:0] FAULT_RANGE  = 8'h80;
    localparam logic [BYTE_W-1:0] STATUS_RANGE = 8'h40;
    localparam logic [BYTE_W-1:0] IDLE_BYTE    = 8'hFF;

    localparam logic [BYTE_W-1:0] FAULT_FIRST_RST  = 8'd5;
    localparam logic [BYTE_W-1:0] FAULT_SECOND_RST = 8'd56;
    localparam logic [BYTE_W-1:0] DISPLAY_ID_RST   = 8'd215;

    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ID   = 2'd2;

    typedef enum logic [1:0] {
        ACT_ADDRESS = 2'd0,
        ACT_DATA    = 2'd1,
        ACT_REARM   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef struct packed {
        logic [BYTE_W-1:0] fault_addr_first;
        logic [BYTE_W-1:0] fault_addr_second;
        logic [BYTE_W-1:0] display_id_byte;
    } cfg_t;

    // Status file write request.
    typedef struct packed {
        logic                    en;
        logic [STATUS_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]       data;
    } wr_t;

    // Result of one transaction, less the status value read back from the file.
    typedef struct packed {
        logic                    tx_valid;
        logic [BYTE_W-1:0]       tx_byte;
        logic                    reg_write_valid;
        logic [STATUS_IDX_W-1:0] reg_index;
        logic                    fault_reply_valid;
        logic [BYTE_W-1:0]       fault_reply;
    } result_t;

endpackage

// File: rtl/i2cdsr_status_ram.sv
module i2cdsr_status_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read and a write to the same entry in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/i2cdsr_ctrl.sv
module i2cdsr_ctrl (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     accept,
    input  logic [1:0]                               action,
    input  logic                                     is_read,
    input  logic [i2cdsr_pkg::BYTE_W-1:0]            bus_byte,
    input  i2cdsr_pkg::cfg_t                         cfg,
    output i2cdsr_pkg::result_t                      res,
    output i2cdsr_pkg::wr_t                          wr
);

    logic [i2cdsr_pkg::BYTE_W-1:0] saved_address_reg, saved_address_next;
    logic                          id_sent_reg, id_sent_next;
    logic                          fetch_pending_reg, fetch_pending_next;
    logic                          fetch_done_reg, fetch_done_next;
    logic                          byte_toggle_reg, byte_toggle_next;
    logic [i2cdsr_pkg::BYTE_W-1:0] last_written_reg, last_written_next;

    i2cdsr_pkg::action_t           act;
    logic [i2cdsr_pkg::BYTE_W-1:0] saved_range;

    assign act         = i2cdsr_pkg::action_t'(action);
    assign saved_range = saved_address_reg & i2cdsr_pkg::RANGE_MASK;

    always_comb
    begin
        saved_address_next = saved_address_reg;
        id_sent_next       = id_sent_reg;
        fetch_pending_next = fetch_pending_reg;
        fetch_done_next    = fetch_done_reg;
        byte_toggle_next   = byte_toggle_reg;
        last_written_next  = last_written_reg;
        res                = '0;
        wr                 = '0;

        unique case (act)
            i2cdsr_pkg::ACT_ADDRESS:
            begin
                saved_address_next = bus_byte;
                if (is_read)
                begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = i2cdsr_pkg::IDLE_BYTE;
                    if (bus_byte == i2cdsr_pkg::DISPLAY_ADDR)
                    begin
                        if (!id_sent_reg)
                        begin
                            res.tx_byte  = cfg.display_id_byte;
                            id_sent_next = 1'b1;
                        end
                        else
                        begin
                            res.tx_byte = last_written_reg;
                        end
                    end
                    else if (((bus_byte & i2cdsr_pkg::RANGE_MASK) == i2cdsr_pkg::FAULT_RANGE)
                             && !fetch_done_reg)
                    begin
                        fetch_pending_next = 1'b1;
                        res.tx_byte        = byte_toggle_reg ? cfg.fault_addr_second
                                                             : cfg.fault_addr_first;
                        byte_toggle_next   = !byte_toggle_reg;
                    end
                end
            end
            i2cdsr_pkg::ACT_DATA:
            begin
                if (!is_read)
                begin
                    if (saved_range == i2cdsr_pkg::STATUS_RANGE)
                    begin
                        wr.en               = 1'b1;
                        wr.idx              = saved_address_reg[i2cdsr_pkg::STATUS_IDX_W:1];
                        wr.data             = bus_byte;
                        res.reg_write_valid = 1'b1;
                        res.reg_index       = saved_address_reg[i2cdsr_pkg::STATUS_IDX_W:1];
                    end
                    else if ((saved_range == i2cdsr_pkg::FAULT_RANGE) && fetch_pending_reg)
                    begin
                        res.fault_reply_valid = 1'b1;
                        res.fault_reply       = bus_byte;
                        fetch_pending_next    = 1'b0;
                        fetch_done_next       = 1'b1;
                    end
                    last_written_next = bus_byte;
                end
            end
            i2cdsr_pkg::ACT_REARM:
            begin
                fetch_done_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_address_reg <= '0;
            id_sent_reg       <= 1'b0;
            fetch_pending_reg <= 1'b0;
            fetch_done_reg    <= 1'b1;
            byte_toggle_reg   <= 1'b0;
            last_written_reg  <= '0;
        end
        else if (accept)
        begin
            saved_address_reg <= saved_address_next;
            id_sent_reg       <= id_sent_next;
            fetch_pending_reg <= fetch_pending_next;
            fetch_done_reg    <= fetch_done_next;
            byte_toggle_reg   <= byte_toggle_next;
            last_written_reg  <= last_written_next;
        end
    end

endmodule

// File: rtl/i2c_display_slave_responder.sv
// Byte-level responder of an I2C slave that answers as a display unit.
// Input channel (in_valid / in_stall): one transaction per bus byte event,
// carrying action, is_read and bus_byte. Output channel (out_valid /
// out_stall): exactly one result transaction for every input transaction,
// in order, with the transmit byte, status write report and fault reply.
// Configuration: a write on cfg_we loads the register selected by cfg_index
// from cfg_data; writes are expected only while the block is idle.
// An accepted transaction passes through the first stage and the output
// register before out_valid rises; the block takes one transaction per cycle
// while the receiver does not stall the output. The output register serves the
// status file: the value reported in reg_value is read back from its synchronous
// memory as the transaction moves from the first stage to the output register.
// Reset returns all responder state to its reset values, loads the
// configuration defaults and empties both pipeline stages; the status
// file memory is not cleared. When the receiver stalls, the output register
// holds its result, and if the first stage is empty one further transaction
// is still accepted into it before in_stall rises.
module i2c_display_slave_responder (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic [1:0]                                   action,
    input  logic                                         is_read,
    input  logic [i2cdsr_pkg::BYTE_W-1:0]                bus_byte,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic                                         tx_valid,
    output logic [i2cdsr_pkg::BYTE_W-1:0]                tx_byte,
    output logic                                         reg_write_valid,
    output logic [i2cdsr_pkg::STATUS_IDX_W-1:0]          reg_index,
    output logic [i2cdsr_pkg::BYTE_W-1:0]                reg_value,
    output logic                                         fault_reply_valid,
    output logic [i2cdsr_pkg::BYTE_W-1:0]                fault_reply,
    input  logic                                         cfg_we,
    input  logic [i2cdsr_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [i2cdsr_pkg::BYTE_W-1:0]                cfg_data
);

    i2cdsr_pkg::cfg_t    cfg_reg;
    i2cdsr_pkg::result_t dec_res;
    i2cdsr_pkg::wr_t     dec_wr;
    i2cdsr_pkg::result_t s1_res_reg;
    i2cdsr_pkg::result_t s2_res_reg;
    logic                s1_valid_reg, s1_valid_next;
    logic                s2_valid_reg;
    logic                accept;
    logic                advance;
    logic                ram_re;
    logic [i2cdsr_pkg::BYTE_W-1:0] ram_rd_data;

    // The output register moves when it is empty or its result is being taken.
    assign advance  = !s2_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_addr_first  <= i2cdsr_pkg::FAULT_FIRST_RST;
            cfg_reg.fault_addr_second <= i2cdsr_pkg::FAULT_SECOND_RST;
            cfg_reg.display_id_byte   <= i2cdsr_pkg::DISPLAY_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cdsr_pkg::CFG_FAULT_FIRST:  cfg_reg.fault_addr_first  <= cfg_data;
                i2cdsr_pkg::CFG_FAULT_SECOND: cfg_reg.fault_addr_second <= cfg_data;
                i2cdsr_pkg::CFG_DISPLAY_ID:   cfg_reg.display_id_byte   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Decision logic and the scalar responder state.
    i2cdsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .action   (action),
        .is_read  (is_read),
        .bus_byte (bus_byte),
        .cfg      (cfg_reg),
        .res      (dec_res),
        .wr       (dec_wr)
    );

    // The status file is written as the transaction is accepted and read back
    // while the transaction sits in the first stage. A later transaction writing
    // the same entry in that cycle does not disturb the read, as the memory
    // returns the old contents.
    assign ram_re = advance && s1_valid_reg && s1_res_reg.reg_write_valid;

    i2cdsr_status_ram #(
        .DEPTH (i2cdsr_pkg::STATUS_DEPTH),
        .WIDTH (i2cdsr_pkg::BYTE_W)
    ) u_status_ram (
        .clk     (clk),
        .we      (accept && dec_wr.en),
        .waddr   (dec_wr.idx),
        .wdata   (dec_wr.data),
        .re      (ram_re),
        .raddr   (s1_res_reg.reg_index),
        .rd_data (ram_rd_data)
    );

    assign s1_valid_next = accept || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= dec_res;
        end
        if (advance)
        begin
            s2_res_reg <= s1_res_reg;
        end
    end

    assign out_valid         = s2_valid_reg;
    assign tx_valid          = s2_res_reg.tx_valid;
    assign tx_byte           = s2_res_reg.tx_byte;
    assign reg_write_valid   = s2_res_reg.reg_write_valid;
    assign reg_index         = s2_res_reg.reg_index;
    assign reg_value         = s2_res_reg.reg_write_valid ? ram_rd_data : '0;
    assign fault_reply_valid = s2_res_reg.fault_reply_valid;
    assign fault_reply       = s2_res_reg.fault_reply;

endmodule

// File: rtl/i2cdsr_port_checker.sv
`include "i2c_display_slave_responder_assert.svh"

module i2cdsr_port_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                tx_valid,
    input logic [i2cdsr_pkg::BYTE_W-1:0]       tx_byte,
    input logic                                reg_write_valid,
    input logic [i2cdsr_pkg::STATUS_IDX_W-1:0] reg_index,
    input logic [i2cdsr_pkg::BYTE_W-1:0]       reg_value,
    input logic                                fault_reply_valid,
    input logic [i2cdsr_pkg::BYTE_W-1:0]       fault_reply
);

    // A stalled result stays in place.
    `I2CDSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(reg_value) && $stable(fault_reply) && $stable(reg_index), "stalled result changed")

    // One transaction causes at most one kind of result.
    `I2CDSR_ASSERT_NOW(a_one_kind, out_valid, $onehot0({tx_valid, reg_write_valid, fault_reply_valid}), "more than one result kind flagged")

    // Fields without their valid flag read as zero.
    `I2CDSR_ASSERT_NOW(a_zero_fields, out_valid, (tx_valid || tx_byte == '0) && (reg_write_valid || (reg_index == '0 && reg_value == '0)) && (fault_reply_valid || fault_reply == '0), "unflagged field not zero")

    // Input is only held off when the output side is full and stalled.
    `I2CDSR_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

endmodule

bind i2c_display_slave_responder i2cdsr_port_checker u_port_checker (.*);
